// ----- hdl/sobel_gradient_products_defines.svh -----
// assertion helpers, the including module provides i_clk and i_rst_n
`ifndef SOBEL_GRADIENT_PRODUCTS_DEFINES_SVH
`define SOBEL_GRADIENT_PRODUCTS_DEFINES_SVH

// same-cycle implication
`define SGP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sgp_pkg.sv -----
package sgp_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 1;
    localparam int ROW_W         = 12;
    localparam int CCOL_W        = 11;
    localparam int SQ_W          = 20;
    localparam int CP_W          = 21;
    localparam int GRAD_W        = 11;
    // wide enough for a 12-bit register and a line length up to 8192
    localparam int CMP_W         = 14;
    localparam int MAX_WIDTH_DEF = 2048;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;

    typedef logic [PIX_W-1:0] t_pix;

    // [row][col], row 0 top, col 2 newest
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic rd;   // pixel transfer, read line stores at its column
        logic wr;   // held pixel moves on: write back, shift window
    } t_win_ctrl;

endpackage

// ----- hdl/sgp_pixel_if.sv -----
interface sgp_pixel_if;
    logic          valid;
    logic          ready;
    sgp_pkg::t_pix pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- hdl/sgp_result_if.sv -----
interface sgp_result_if;
    logic                               valid;
    logic                               ready;
    logic [sgp_pkg::SQ_W-1:0]           vertical_sq;
    logic [sgp_pkg::SQ_W-1:0]           horizontal_sq;
    logic signed [sgp_pkg::CP_W-1:0]    cross_product;
    logic [sgp_pkg::CCOL_W-1:0]         center_col;
    logic [sgp_pkg::ROW_W-1:0]          center_row;
    logic                               frame_last;

    modport source (
        output valid, output vertical_sq, output horizontal_sq, output cross_product,
        output center_col, output center_row, output frame_last, input ready
    );
    modport sink (
        input valid, input vertical_sq, input horizontal_sq, input cross_product,
        input center_col, input center_row, input frame_last, output ready
    );
endinterface

// ----- hdl/sgp_window.sv -----
module sgp_window #(
    parameter int MAX_WIDTH = sgp_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  sgp_pkg::t_win_ctrl             i_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_rd_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_wr_col,
    input  sgp_pkg::t_pix                  i_px,
    output sgp_pkg::t_window               o_window
);

    localparam int PW = sgp_pkg::PIX_W;

    // both line stores side by side: [2*PW-1:PW] two rows up, [PW-1:0] one row up
    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd_data;
    logic [2*PW-1:0] r_fwd_data;
    logic            r_fwd;
    logic [2*PW-1:0] rd_data;
    logic [2*PW-1:0] wr_data;
    sgp_pkg::t_window r_win;

    assign rd_data = r_fwd ? r_fwd_data : r_rd_data;
    // column moves down one row
    assign wr_data = {rd_data[PW-1:0], i_px};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[i_wr_col] <= wr_data;
        end
        if (i_ctrl.rd) begin
            r_rd_data  <= r_mem[i_rd_col];
            r_fwd      <= i_ctrl.wr && (i_wr_col == i_rd_col);
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= rd_data[2*PW-1:PW];
            r_win[1][2] <= rd_data[PW-1:0];
            r_win[2][2] <= i_px;
        end
    end

    assign o_window = r_win;

endmodule

// ----- hdl/sgp_grad.sv -----
module sgp_grad (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  sgp_pkg::t_window                     i_window,
    output logic [sgp_pkg::SQ_W-1:0]             o_vertical_sq,
    output logic [sgp_pkg::SQ_W-1:0]             o_horizontal_sq,
    output logic signed [sgp_pkg::CP_W-1:0]      o_cross_product
);

    localparam int GW = sgp_pkg::GRAD_W;
    localparam int SW = sgp_pkg::GRAD_W - 1;

    logic [SW-1:0]          bot_sum, top_sum, rgt_sum, lft_sum;
    logic signed [GW-1:0]   gv, gh;
    logic signed [GW-1:0]   r_gv, r_gh;
    logic signed [2*GW-1:0] vv, hh, vh;
    logic [sgp_pkg::SQ_W-1:0]        r_vsq, r_hsq;
    logic signed [sgp_pkg::CP_W-1:0] r_cp;

    // 1,2,1 weighted sums of the outer rows and columns
    assign bot_sum = SW'(i_window[2][0]) + {1'b0, i_window[2][1], 1'b0} + SW'(i_window[2][2]);
    assign top_sum = SW'(i_window[0][0]) + {1'b0, i_window[0][1], 1'b0} + SW'(i_window[0][2]);
    assign rgt_sum = SW'(i_window[0][2]) + {1'b0, i_window[1][2], 1'b0} + SW'(i_window[2][2]);
    assign lft_sum = SW'(i_window[0][0]) + {1'b0, i_window[1][0], 1'b0} + SW'(i_window[2][0]);

    assign gv = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    assign gh = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum});

    assign vv = r_gv * r_gv;
    assign hh = r_gh * r_gh;
    assign vh = r_gv * r_gh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gv  <= gv;
            r_gh  <= gh;
            r_vsq <= vv[sgp_pkg::SQ_W-1:0];
            r_hsq <= hh[sgp_pkg::SQ_W-1:0];
            r_cp  <= vh[sgp_pkg::CP_W-1:0];
        end
    end

    assign o_vertical_sq   = r_vsq;
    assign o_horizontal_sq = r_hsq;
    assign o_cross_product = r_cp;

endmodule

// ----- hdl/sobel_gradient_products.sv -----
// channel    dir  payload                                           transfer
// i_pix      in   pixel                                             valid & ready
// o_res      out  vertical_sq horizontal_sq cross_product           valid & ready
//                 center_col center_row frame_last
// i_cfg_*    in   i_cfg_idx i_cfg_data                              i_cfg_we
//
// one pixel per cycle unless stalled; each result follows its pixel through the pipeline
// line stores are read at the pixel's column and written back as the pixel leaves stage 1
// all stages move together: ready drops only while a held result is not taken
// sync reset clears counters and valids, presets geometry; line stores are not cleared
module sobel_gradient_products #(
    parameter int MAX_WIDTH = sgp_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sgp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgp_pkg::CFG_W-1:0]         i_cfg_data,
    sgp_pixel_if.sink                         i_pix,
    sgp_result_if.source                      o_res
);

`include "sobel_gradient_products_defines.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = sgp_pkg::CMP_W;
    localparam int RW = sgp_pkg::ROW_W;
    localparam int XW = sgp_pkg::CCOL_W;
    localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

    logic [sgp_pkg::CFG_W-1:0] r_image_width, r_image_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic en, take, last_col, last_row, emit;
    logic [EW-1:0] col_ext, col_inc, wid_ext;
    logic [RW:0]   row_inc;

    // pipeline: 1 read, 2 window, 3 gradients, 4 products
    logic          r1_v, r2_v, r3_v, r4_v;
    logic          r1_emit, r2_emit, r3_emit, r4_emit;
    sgp_pkg::t_pix r1_px;
    logic [CW-1:0] r1_col;
    logic [XW-1:0] r1_ccol, r2_ccol, r3_ccol, r4_ccol;
    logic [RW-1:0] r1_crow, r2_crow, r3_crow, r4_crow;
    logic          r1_last, r2_last, r3_last, r4_last;

    sgp_pkg::t_win_ctrl win_ctrl;
    sgp_pkg::t_window   window;

    assign en   = !(r4_v && r4_emit) || o_res.ready;
    assign take = en && i_pix.valid;
    assign i_pix.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sgp_pkg::WIDTH_RESET;
            r_image_height <= sgp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgp_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                sgp_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position bookkeeping
    assign col_ext = EW'(r_col);
    assign col_inc = col_ext + 1'b1;
    assign wid_ext = EW'(r_image_width);
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_comb begin
        priority if (r_image_width < sgp_pkg::MIN_DIM) begin
            last_col = col_inc >= EW'(sgp_pkg::MIN_DIM);
        end else if (wid_ext > MAXW) begin
            last_col = col_inc >= MAXW;
        end else begin
            last_col = col_inc >= wid_ext;
        end
        if (r_image_height < sgp_pkg::MIN_DIM) begin
            last_row = row_inc >= (RW + 1)'(sgp_pkg::MIN_DIM);
        end else begin
            last_row = row_inc >= {1'b0, r_image_height};
        end
    end

    assign emit = (r_row >= RW'(2)) && (col_ext >= EW'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[RW-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_pix.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px   <= i_pix.pixel;
            r1_col  <= r_col;
            r1_emit <= emit;
            r1_ccol <= XW'(col_ext - 1'b1);
            r1_crow <= r_row - 1'b1;
            r1_last <= last_col && last_row;
            r2_emit <= r1_emit;
            r2_ccol <= r1_ccol;
            r2_crow <= r1_crow;
            r2_last <= r1_last;
            r3_emit <= r2_emit;
            r3_ccol <= r2_ccol;
            r3_crow <= r2_crow;
            r3_last <= r2_last;
            r4_emit <= r3_emit;
            r4_ccol <= r3_ccol;
            r4_crow <= r3_crow;
            r4_last <= r3_last;
        end
    end

    assign win_ctrl.rd = take;
    assign win_ctrl.wr = en && r1_v;

    sgp_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_ctrl   (win_ctrl),
        .i_rd_col (r_col),
        .i_wr_col (r1_col),
        .i_px     (r1_px),
        .o_window (window)
    );

    sgp_grad u_grad (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_window        (window),
        .o_vertical_sq   (o_res.vertical_sq),
        .o_horizontal_sq (o_res.horizontal_sq),
        .o_cross_product (o_res.cross_product)
    );

    // border pixels travel as bubbles
    assign o_res.valid      = r4_v && r4_emit;
    assign o_res.center_col = r4_ccol;
    assign o_res.center_row = r4_crow;
    assign o_res.frame_last = r4_last;

    `SGP_ASSERT_NEXT(a_col_wrap, take && last_col, r_col == '0, "column did not wrap")
    `SGP_ASSERT_NEXT(a_col_step, take && !last_col, r_col == CW'($past(r_col) + 1'b1), "column skipped")
    `SGP_ASSERT_NOW(a_center_inner, o_res.valid, (o_res.center_col != '0) && (o_res.center_row != '0), "border result")
    `SGP_ASSERT_NOW(a_ready_stall, !i_pix.ready, o_res.valid && !o_res.ready, "stall without held result")

endmodule
